// ===== sv/tcba_pkg.sv =====
package tcba_pkg;

  // Fixed field widths
  localparam int unsigned AddrW    = 14;
  localparam int unsigned SizeW    = 3;
  localparam int unsigned BitSelW  = 5;
  localparam int unsigned WordW    = 32;
  // Widest word index the table can need (up to 256 words)
  localparam int unsigned IdxMaxW  = 8;

  // Request codes
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqMark  = 1'b1;

  // Largest size that still starts at the small-slot half
  localparam logic [SizeW-1:0] SmallSizeMax = 3'd2;

  typedef struct packed {
    logic             req_type;
    logic [SizeW-1:0] alloc_size;
    logic [AddrW-1:0] mark_address;
  } in_t;

  typedef struct packed {
    logic [AddrW-1:0] slot_address;
    logic             out_of_memory;
  } out_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic               is_mark;
    logic               mark_ok;
    logic [IdxMaxW-1:0] word;
    logic [BitSelW-1:0] bit_sel;
  } cmd_t;

endpackage

// ===== sv/tcba_front.sv =====
module tcba_front #(
  parameter int unsigned TABLE_WORDS = 64
) (
  input  tcba_pkg::in_t  in_data_i,
  output tcba_pkg::cmd_t cmd_o
);

  localparam int unsigned Half = TABLE_WORDS / 2;

  logic [8:0] mark_idx;
  logic       upper;

  // Mark decode: low nibble picks the half, address/512 picks the word
  assign upper    = (in_data_i.mark_address[3:0] != 4'd0);
  assign mark_idx = {4'd0, in_data_i.mark_address[13:9]} + (upper ? 9'(Half) : 9'd0);

  always_comb begin
    cmd_o         = '0;
    cmd_o.is_mark = (in_data_i.req_type == tcba_pkg::ReqMark);
    cmd_o.bit_sel = in_data_i.mark_address[8:4];
    if (cmd_o.is_mark) begin
      cmd_o.mark_ok = (mark_idx < 9'(TABLE_WORDS));
      cmd_o.word    = tcba_pkg::IdxMaxW'(mark_idx);
    end else begin
      // small requests scan from word 0, larger ones from the upper half
      cmd_o.mark_ok = 1'b0;
      if (in_data_i.alloc_size inside {[3'd0:tcba_pkg::SmallSizeMax]}) begin
        cmd_o.word = '0;
      end else begin
        cmd_o.word = tcba_pkg::IdxMaxW'(Half);
      end
    end
  end

endmodule

// ===== sv/tcba_queue.sv =====
module tcba_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcba_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tcba_pkg::cmd_t pop_data_o
);

  tcba_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/tcba_back.sv =====
module tcba_back #(
  parameter int unsigned TABLE_WORDS = 64,
  parameter int unsigned MEM_BYTES   = 16384
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  tcba_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcba_pkg::out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(TABLE_WORDS);
  localparam int unsigned Half = TABLE_WORDS / 2;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_WORDS - 1);
  localparam logic [IdxW-1:0] HalfIdx = IdxW'(Half);
  localparam logic [tcba_pkg::AddrW-1:0] OomAddr = tcba_pkg::AddrW'(MEM_BYTES - 10);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  // Position of the single set bit of a one-hot word
  function automatic logic [tcba_pkg::BitSelW-1:0] onehot_pos(input logic [31:0] oh);
    logic [tcba_pkg::BitSelW-1:0] pos;
    pos = '0;
    for (int k = 0; k < 5; k++) begin
      for (int b = 0; b < 32; b++) begin
        if (((b >> k) & 1) == 1) begin
          pos[k] = pos[k] | oh[b];
        end
      end
    end
    return pos;
  endfunction

  logic [2:0]                   state_q, state_d;
  logic [31:0]                  mem_q [TABLE_WORDS];
  logic [TABLE_WORDS-1:0]       vld_q;
  logic [31:0]                  rdata_q;
  logic                         rvld_q;
  logic [IdxW-1:0]              rd_idx_q;
  logic [IdxW-1:0]              raddr;
  logic                         we;
  logic [31:0]                  wdata;
  logic [tcba_pkg::BitSelW-1:0] bit_q, bit_d;
  tcba_pkg::out_t               res_q, res_d;
  tcba_pkg::out_t               out_q;
  logic                         out_valid_q;
  logic                         out_load;

  logic [31:0]                  rword;
  logic [31:0]                  free;
  logic [31:0]                  first_free;
  logic [tcba_pkg::BitSelW-1:0] jpos;
  logic                         upper;
  logic [IdxW-1:0]              woff;
  logic [tcba_pkg::AddrW-1:0]   alloc_addr;

  // Word as read; never-written words read as free
  assign rword      = rvld_q ? rdata_q : '0;
  assign free       = ~rword;
  assign first_free = free & (~free + 32'd1);
  assign jpos       = onehot_pos(first_free);
  assign upper      = (rd_idx_q >= HalfIdx);
  assign woff       = upper ? (rd_idx_q - HalfIdx) : rd_idx_q;
  assign alloc_addr = tcba_pkg::AddrW'({woff, jpos, 4'b0000}) |
                      (upper ? tcba_pkg::AddrW'(6) : '0);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer: one word read per cycle while scanning
  always_comb begin
    state_d = state_q;
    raddr   = rd_idx_q + IdxW'(1);
    we      = 1'b0;
    wdata   = rword | first_free;
    bit_d   = bit_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        raddr = cmd_i.word[IdxW-1:0];
        bit_d = cmd_i.bit_sel;
        if (cmd_valid_i) begin
          if (!cmd_i.is_mark) begin
            state_d = S_SCAN;
          end else if (cmd_i.mark_ok) begin
            state_d = S_MARK;
          end else begin
            res_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (|free) begin
          we                  = 1'b1;
          res_d.slot_address  = alloc_addr;
          res_d.out_of_memory = 1'b0;
          state_d             = S_DONE;
        end else if (rd_idx_q == LastIdx) begin
          res_d.slot_address  = OomAddr;
          res_d.out_of_memory = 1'b1;
          state_d             = S_DONE;
        end
      end
      S_MARK: begin
        we      = 1'b1;
        wdata   = rword | (32'd1 << bit_q);
        res_d   = '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= vld_q[raddr];
      if (we) begin
        vld_q[rd_idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Bitmap memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[rd_idx_q] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= raddr;
    bit_q    <= bit_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

endmodule

// ===== sv/two_class_bitmap_slot_allocator_core.sv =====
// Two-class bitmap slot allocator, first fit.
// Input channel (in_valid_i/in_ready_o, in_data_i): one beat is one request,
// either an allocate of 1 to 4 bytes or a mark of a given byte address.
// Output channel (out_valid_o/out_ready_i, out_data_o): exactly one beat per
// request, in request order; mark requests return an all-zero beat.
// A two-entry command queue sits between the decoder and the scan engine,
// so up to two more requests are taken while the engine is busy.
// Flow, input beat to out_valid_o: the request passes the queue; an allocate
// then scans bitmap words, at most TABLE_WORDS of them, and a mark sets its
// bit, or skips the memory when its word index is past the table. The scan
// engine reads one word per cycle from the bitmap memory and handles
// one request at a time; it takes a new request once the last result is loaded.
// Reset clears every word's valid flag, so the whole table reads as free at
// once; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register and the
// engine waits with the next result; the queue keeps taking input until full.
module two_class_bitmap_slot_allocator_core #(
  parameter int unsigned TABLE_WORDS = 64,
  parameter int unsigned MEM_BYTES   = 16384
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcba_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcba_pkg::out_t out_data_o
);

  localparam logic [tcba_pkg::AddrW-1:0] OomAddr = tcba_pkg::AddrW'(MEM_BYTES - 10);

  tcba_pkg::cmd_t front_cmd;
  tcba_pkg::cmd_t q_cmd;
  logic           q_full;
  logic           q_valid;
  logic           cmd_ready;

  assign in_ready_o = !q_full;

  // Decode and classify
  tcba_front #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_front (
    .in_data_i(in_data_i),
    .cmd_o    (front_cmd)
  );

  // Command queue
  tcba_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i && !q_full),
    .push_data_i(front_cmd),
    .full_o     (q_full),
    .pop_i      (q_valid && cmd_ready),
    .valid_o    (q_valid),
    .pop_data_o (q_cmd)
  );

  // Scan engine and output register
  tcba_back #(
    .TABLE_WORDS(TABLE_WORDS),
    .MEM_BYTES  (MEM_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_ready_o(cmd_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  // A full-table result always carries the fixed fallback address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_of_memory |-> out_data_o.slot_address == OomAddr)
    else $error("out_of_memory beat with wrong address");

  // Input back-pressure only comes from a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("input stalled with empty queue");

  // A queued command is not dropped while the engine is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !cmd_ready |=> q_valid)
    else $error("queued command lost");
`endif

endmodule
